### src/owm_pkg.sv
package owm_pkg;

    // Widths of the configuration port.
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 3;

    // Fixed recovery gap after the last write slot, in ticks.
    localparam logic [7:0] WRITE_TAIL_TICKS = 8'd65;

    // Command codes on the func field.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RESET = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_WRITE_LOW     = 3'd3,
        REG_WRITE_HOLD    = 3'd4,
        REG_READ_LOW      = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } cfg_index_t;

    // Timing registers as seen by the sequencer.
    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_wait_ticks;
        logic [8:0] reset_tail_ticks;
        logic [5:0] write_low_ticks;
        logic [7:0] write_hold_ticks;
        logic [5:0] read_low_ticks;
        logic [5:0] read_sample_ticks;
        logic [7:0] read_tail_ticks;
    } cfg_t;

    // One result transaction.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

endpackage

### src/one_wire_bus_master.sv
// Single-wire bus master driven by a stream of microsecond ticks and commands
// (func 0 tick, 1 bus reset, 2 write byte, 3 read byte), with one result
// transaction per input transaction that reports the line drive, busy, done,
// the last read byte and whether a command was rejected for arriving while
// busy. Every input transaction is handled by the phase sequencer and its
// tick counter, so one transaction can be accepted each cycle while in_stall
// is low; results are registered in a two-entry output register with skid
// stage that lets input flow for one more transaction while the output is
// stalled. Timing registers are written through the configuration port; the
// user must do so only while no command is running; the block does not enforce it.
module one_wire_bus_master (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        func,
    input  logic [7:0]                        write_data,
    input  logic                              line_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              drive_low,
    output logic                              busy_res,
    output logic                              done_res,
    output logic [7:0]                        read_data,
    output logic                              rejected
);
    import owm_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic step_en;
    logic full;

    assign in_stall = full;
    assign step_en  = in_valid && !full;

    // Timing registers.
    owm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Phase sequencer.
    owm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .func       (func),
        .write_data (write_data),
        .line_level (line_level),
        .cfg        (cfg),
        .res        (res)
    );

    // Result register with skid stage.
    owm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_en),
        .res       (res),
        .out_stall (out_stall),
        .full      (full),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign drive_low = out_res.drive_low;
    assign busy_res  = out_res.busy_res;
    assign done_res  = out_res.done_res;
    assign read_data = out_res.read_data;
    assign rejected  = out_res.rejected;

endmodule

### src/owm_cfg.sv
module owm_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [owm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output owm_pkg::cfg_t                     cfg
);
    import owm_pkg::*;

    cfg_t cfg_reg;

    // Timing registers; each write keeps the low bits that the register holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks     <= 10'd480;
            cfg_reg.presence_wait_ticks <= 8'd60;
            cfg_reg.reset_tail_ticks    <= 9'd240;
            cfg_reg.write_low_ticks     <= 6'd5;
            cfg_reg.write_hold_ticks    <= 8'd55;
            cfg_reg.read_low_ticks      <= 6'd10;
            cfg_reg.read_sample_ticks   <= 6'd10;
            cfg_reg.read_tail_ticks     <= 8'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RESET_LOW:     cfg_reg.reset_low_ticks     <= cfg_data[9:0];
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_ticks <= cfg_data[7:0];
                REG_RESET_TAIL:    cfg_reg.reset_tail_ticks    <= cfg_data[8:0];
                REG_WRITE_LOW:     cfg_reg.write_low_ticks     <= cfg_data[5:0];
                REG_WRITE_HOLD:    cfg_reg.write_hold_ticks    <= cfg_data[7:0];
                REG_READ_LOW:      cfg_reg.read_low_ticks      <= cfg_data[5:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_ticks   <= cfg_data[5:0];
                REG_READ_TAIL:     cfg_reg.read_tail_ticks     <= cfg_data[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/owm_core.sv
module owm_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [1:0]    func,
    input  logic [7:0]    write_data,
    input  logic          line_level,
    input  owm_pkg::cfg_t cfg,
    output owm_pkg::res_t res
);
    import owm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HOLD  = 4'd5,
        PH_WR_TAIL  = 4'd6,
        PH_RD_LOW   = 4'd7,
        PH_RD_WAIT  = 4'd8,
        PH_RD_TAIL  = 4'd9
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [9:0] tick_count_reg, tick_count_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] read_hold_reg, read_hold_next;

    logic [9:0] raw_len;
    logic [9:0] phase_len;
    logic [9:0] tick_inc;
    logic [2:0] bit_inc;
    logic       done;
    logic       rej;

    // Length of the current phase; a zero length counts as one tick.
    always_comb
    begin
        unique case (phase_reg)
            PH_RST_LOW:  raw_len = cfg.reset_low_ticks;
            PH_RST_WAIT: raw_len = {2'b00, cfg.presence_wait_ticks};
            PH_RST_TAIL: raw_len = {1'b0, cfg.reset_tail_ticks};
            PH_WR_LOW:   raw_len = {4'b0000, cfg.write_low_ticks};
            PH_WR_HOLD:  raw_len = {2'b00, cfg.write_hold_ticks};
            PH_WR_TAIL:  raw_len = {2'b00, WRITE_TAIL_TICKS};
            PH_RD_LOW:   raw_len = {4'b0000, cfg.read_low_ticks};
            PH_RD_WAIT:  raw_len = {4'b0000, cfg.read_sample_ticks};
            default:     raw_len = {2'b00, cfg.read_tail_ticks};
        endcase
        phase_len = (raw_len == 10'd0) ? 10'd1 : raw_len;
    end

    assign tick_inc = tick_count_reg + 10'd1;
    assign bit_inc  = bit_index_reg + 3'd1;

    // One transaction: a tick advances the sequencer, a command starts it.
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        read_hold_next  = read_hold_reg;
        done            = 1'b0;
        rej             = 1'b0;

        if (step_en)
        begin
            priority if (func == FUNC_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (tick_inc < phase_len)
                    begin
                        tick_count_next = tick_inc;
                    end
                    else
                    begin
                        tick_count_next = '0;
                        unique case (phase_reg)
                            PH_RST_LOW: phase_next = PH_RST_WAIT;
                            PH_RST_WAIT:
                            begin
                                // A high level means no presence pulse: retry.
                                if (line_level)
                                    phase_next = PH_RST_LOW;
                                else if (cfg.reset_tail_ticks == 9'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                    phase_next = PH_RST_TAIL;
                            end
                            PH_WR_LOW: phase_next = PH_WR_HOLD;
                            PH_WR_HOLD:
                            begin
                                shift_next     = {1'b0, shift_reg[7:1]};
                                bit_index_next = bit_inc;
                                if (bit_inc != 3'd0)
                                    phase_next = PH_WR_LOW;
                                else if (WRITE_TAIL_TICKS == 8'd0)
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                    phase_next = PH_WR_TAIL;
                            end
                            PH_RD_LOW: phase_next = PH_RD_WAIT;
                            PH_RD_WAIT:
                            begin
                                shift_next = {line_level, shift_reg[7:1]};
                                if (cfg.read_tail_ticks != 8'd0)
                                    phase_next = PH_RD_TAIL;
                                else
                                begin
                                    bit_index_next = bit_inc;
                                    if (bit_inc == 3'd0)
                                    begin
                                        read_hold_next = shift_next;
                                        phase_next     = PH_IDLE;
                                        done           = 1'b1;
                                    end
                                    else
                                        phase_next = PH_RD_LOW;
                                end
                            end
                            PH_RD_TAIL:
                            begin
                                bit_index_next = bit_inc;
                                if (bit_inc == 3'd0)
                                begin
                                    read_hold_next = shift_reg;
                                    phase_next     = PH_IDLE;
                                    done           = 1'b1;
                                end
                                else
                                    phase_next = PH_RD_LOW;
                            end
                            default:
                            begin
                                // Both tails end the command.
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                bit_index_next  = 3'd0;
                tick_count_next = '0;
                priority if (func == FUNC_RESET)
                    phase_next = PH_RST_LOW;
                else if (func == FUNC_WRITE)
                begin
                    shift_next = write_data;
                    phase_next = PH_WR_LOW;
                end
                else
                begin
                    shift_next = '0;
                    phase_next = PH_RD_LOW;
                end
            end
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            read_hold_reg  <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            read_hold_reg  <= read_hold_next;
        end
    end

    // The result shows the state after the transaction.
    always_comb
    begin
        res.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW) ||
                        (phase_next == PH_RD_LOW) ||
                        ((phase_next == PH_WR_HOLD) && !shift_next[0]);
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.read_data = read_hold_next;
        res.rejected  = rej;
    end

endmodule

### src/owm_out.sv
module owm_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  owm_pkg::res_t res,
    input  logic          out_stall,
    output logic          full,
    output logic          out_valid,
    output owm_pkg::res_t out_res
);
    import owm_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic take;

    assign take = out_valid_reg && !out_stall;

    // Valid bits of the output register and of the skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !take)
                skid_data_reg <= res;
            else
                out_data_reg <= res;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_data_reg;

endmodule

### src/owm_checker.sv
module owm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       drive_low,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_data,
    input logic       rejected
);

    // A rejected command leaves the running command in place.
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> busy_res)
        else $error("rejected transaction without a running command");

    // A command that completes leaves the master idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done reported while still busy");

    // The line is only pulled low during a command.
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_low |-> busy_res)
        else $error("line driven low while idle");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("stalled result changed");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_low (drive_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_data (read_data),
    .rejected  (rejected)
);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import owm_pkg::*;

    localparam int NUM_REGS = 8;
    localparam int RANDOM_ITEMS = 200;

    // Register widths in index order, used to put junk above the live bits.
    localparam int REG_W [NUM_REGS] = '{10, 8, 9, 6, 8, 6, 6, 8};

    typedef logic [CFG_DATA_W-1:0] reg_vals_t [NUM_REGS];

    // Sequencer phases of the bus master.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_HOLD,
        PH_WR_TAIL,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL
    } bus_phase_t;

    // Result transactions that can be written down without working them out.
    localparam res_t RES_IDLE   = '0;
    localparam res_t RES_START  = {1'b1, 1'b1, 1'b0, 8'h00, 1'b0};
    localparam res_t RES_REJECT = {1'b1, 1'b1, 1'b0, 8'h00, 1'b1};

    // One row of the directed sequence. A row with drain set sends nothing
    // itself but runs ticks until the command in progress has finished.
    typedef struct packed {
        logic [1:0] fn;
        logic [7:0] data;
        logic       level;
        logic       typed;
        logic       drain;
        res_t       want;
    } dir_row_t;

    localparam int N_DIR = 8;

    dir_row_t dir_rows [N_DIR] = '{
        '{FUNC_TICK,  8'h00, 1'b0, 1'b1, 1'b0, RES_IDLE},
        '{FUNC_TICK,  8'hFF, 1'b1, 1'b1, 1'b0, RES_IDLE},
        '{FUNC_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, RES_START},
        '{FUNC_RESET, 8'h00, 1'b0, 1'b1, 1'b0, RES_REJECT},
        '{FUNC_READ,  8'hA5, 1'b1, 1'b1, 1'b0, RES_REJECT},
        '{FUNC_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, RES_REJECT},
        '{FUNC_TICK,  8'h00, 1'b1, 1'b1, 1'b0, RES_START},
        '{FUNC_TICK,  8'h00, 1'b0, 1'b0, 1'b1, RES_IDLE}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_RESET_LOW;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             func = FUNC_TICK;
    logic [7:0]             write_data = 8'h00;
    logic                   line_level = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   drive_low;
    logic                   busy_res;
    logic                   done_res;
    logic [7:0]             read_data;
    logic                   rejected;

    // Predictor state and its copy of the timing registers.
    cfg_t       cur_cfg;
    bus_phase_t seq_ph = PH_IDLE;
    logic [9:0] tick_cnt = '0;
    logic [2:0] bit_idx = '0;
    logic [7:0] shreg = '0;
    logic [7:0] read_hold = '0;

    res_t bus_res_due [$];

    bit no_idle = 1'b0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int dones_seen = 0;
    int rejects_seen = 0;
    int settings_run = 0;

    one_wire_bus_master u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .write_data (write_data),
        .line_level (line_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive_low  (drive_low),
        .busy_res   (busy_res),
        .done_res   (done_res),
        .read_data  (read_data),
        .rejected   (rejected)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void enter_phase(bus_phase_t p);
        seq_ph = p;
        tick_cnt = '0;
    endfunction

    // Advances the predicted sequencer by one input transaction and returns
    // the result transaction it should produce.
    function automatic res_t bus_step(logic [1:0] fn, logic [7:0] data, logic level);
        res_t r;
        logic done;
        logic rej;
        logic slot_end;
        logic [9:0] len;
        done = 1'b0;
        rej = 1'b0;
        slot_end = 1'b0;
        if (fn == FUNC_TICK)
        begin
            if (seq_ph != PH_IDLE)
            begin
                // A phase of length zero still takes one tick, except the tails.
                case (seq_ph)
                    PH_RST_LOW:  len = cur_cfg.reset_low_ticks;
                    PH_RST_WAIT: len = 10'(cur_cfg.presence_wait_ticks);
                    PH_RST_TAIL: len = 10'(cur_cfg.reset_tail_ticks);
                    PH_WR_LOW:   len = 10'(cur_cfg.write_low_ticks);
                    PH_WR_HOLD:  len = 10'(cur_cfg.write_hold_ticks);
                    PH_WR_TAIL:  len = 10'(WRITE_TAIL_TICKS);
                    PH_RD_LOW:   len = 10'(cur_cfg.read_low_ticks);
                    PH_RD_WAIT:  len = 10'(cur_cfg.read_sample_ticks);
                    default:     len = 10'(cur_cfg.read_tail_ticks);
                endcase
                if (len == '0)
                    len = 10'd1;
                tick_cnt = tick_cnt + 10'd1;
                if (tick_cnt >= len)
                begin
                    case (seq_ph)
                        PH_RST_LOW:
                            enter_phase(PH_RST_WAIT);
                        PH_RST_WAIT:
                            // No presence pulse: the whole reset starts over.
                            if (level)
                                enter_phase(PH_RST_LOW);
                            else if (cur_cfg.reset_tail_ticks == '0)
                            begin
                                enter_phase(PH_IDLE);
                                done = 1'b1;
                            end
                            else
                                enter_phase(PH_RST_TAIL);
                        PH_WR_LOW:
                            enter_phase(PH_WR_HOLD);
                        PH_WR_HOLD:
                        begin
                            shreg = shreg >> 1;
                            bit_idx = bit_idx + 3'd1;
                            if (bit_idx != '0)
                                enter_phase(PH_WR_LOW);
                            else if (WRITE_TAIL_TICKS == 0)
                            begin
                                enter_phase(PH_IDLE);
                                done = 1'b1;
                            end
                            else
                                enter_phase(PH_WR_TAIL);
                        end
                        PH_RD_LOW:
                            enter_phase(PH_RD_WAIT);
                        PH_RD_WAIT:
                        begin
                            shreg = {level, shreg[7:1]};
                            if (cur_cfg.read_tail_ticks == '0)
                                slot_end = 1'b1;
                            else
                                enter_phase(PH_RD_TAIL);
                        end
                        PH_RD_TAIL:
                            slot_end = 1'b1;
                        default:
                        begin
                            enter_phase(PH_IDLE);
                            done = 1'b1;
                        end
                    endcase
                    // End of a read slot: next slot, or the byte is complete.
                    if (slot_end)
                    begin
                        bit_idx = bit_idx + 3'd1;
                        if (bit_idx == '0)
                        begin
                            read_hold = shreg;
                            enter_phase(PH_IDLE);
                            done = 1'b1;
                        end
                        else
                            enter_phase(PH_RD_LOW);
                    end
                end
            end
        end
        else if (seq_ph != PH_IDLE)
            rej = 1'b1;
        else
        begin
            bit_idx = '0;
            case (fn)
                FUNC_RESET:
                    enter_phase(PH_RST_LOW);
                FUNC_WRITE:
                begin
                    shreg = data;
                    enter_phase(PH_WR_LOW);
                end
                default:
                begin
                    shreg = '0;
                    enter_phase(PH_RD_LOW);
                end
            endcase
        end
        r.drive_low = (seq_ph == PH_RST_LOW) || (seq_ph == PH_WR_LOW) ||
                      (seq_ph == PH_RD_LOW) || (seq_ph == PH_WR_HOLD && !shreg[0]);
        r.busy_res  = (seq_ph != PH_IDLE);
        r.done_res  = done;
        r.read_data = read_hold;
        r.rejected  = rej;
        return r;
    endfunction

    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // The presence sample is mostly low so that bus resets end soon.
    function automatic logic pick_level();
        if (seq_ph == PH_RST_WAIT)
            return ($urandom_range(0, 3) == 0);
        return 1'($urandom_range(0, 1));
    endfunction

    // Sends one input transaction and queues the result it should give.
    task automatic send_item(logic [1:0] fn, logic [7:0] data, logic level,
                             logic typed, res_t want);
        int gap;
        res_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        write_data <= data;
        line_level <= level;
        do @(posedge clk); while (in_stall);
        r = bus_step(fn, data, level);
        bus_res_due.push_back(typed ? want : r);
        items_sent++;
    endtask

    // Ticks until the command in progress is over, with the odd command
    // thrown in that the master has to turn away.
    task automatic drain_ticks();
        while (seq_ph != PH_IDLE)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(2'($urandom_range(FUNC_RESET, FUNC_READ)), 8'($urandom),
                          1'($urandom), 1'b0, RES_IDLE);
            else
                send_item(FUNC_TICK, 8'($urandom), pick_level(), 1'b0, RES_IDLE);
        end
    endtask

    // Writes all timing registers once the master and the result queue are idle.
    task automatic apply_cfg(reg_vals_t vals);
        in_valid <= 1'b0;
        while (bus_res_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            cfg_data <= vals[i];
            case (cfg_index_t'(i))
                REG_RESET_LOW:     cur_cfg.reset_low_ticks = vals[i][9:0];
                REG_PRESENCE_WAIT: cur_cfg.presence_wait_ticks = vals[i][7:0];
                REG_RESET_TAIL:    cur_cfg.reset_tail_ticks = vals[i][8:0];
                REG_WRITE_LOW:     cur_cfg.write_low_ticks = vals[i][5:0];
                REG_WRITE_HOLD:    cur_cfg.write_hold_ticks = vals[i][7:0];
                REG_READ_LOW:      cur_cfg.read_low_ticks = vals[i][5:0];
                REG_READ_SAMPLE:   cur_cfg.read_sample_ticks = vals[i][5:0];
                default:           cur_cfg.read_tail_ticks = vals[i][7:0];
            endcase
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    // One timing setting: the first three commands are reset, write and read,
    // the rest are drawn at random. Idle ticks sometimes come in between.
    task automatic run_setting(reg_vals_t vals, int n_cmds);
        logic [1:0] fn;
        logic [7:0] data;
        apply_cfg(vals);
        for (int k = 0; k < n_cmds; k++)
        begin
            if (k < 3)
                fn = 2'(FUNC_RESET + k);
            else
                fn = 2'($urandom_range(FUNC_RESET, FUNC_READ));
            data = ($urandom_range(0, 3) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                send_item(FUNC_TICK, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
            send_item(fn, data, 1'($urandom), 1'b0, RES_IDLE);
            drain_ticks();
        end
    endtask

    // The result side stalls a random number of cycles before each transaction.
    initial
    begin
        int hold;
        @(posedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            dones_seen += (done_res === 1'b1);
            rejects_seen += (rejected === 1'b1);
            if (bus_res_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result expected none, actual %b %b %b %h %b", $time,
                             drive_low, busy_res, done_res, read_data, rejected);
            end
            else
            begin
                want = bus_res_due.pop_front();
                check_field("drive_low", 8'(want.drive_low), 8'(drive_low));
                check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                check_field("done_res", 8'(want.done_res), 8'(done_res));
                check_field("read_data", want.read_data, read_data);
                check_field("rejected", 8'(want.rejected), 8'(rejected));
            end
        end
    end

    // Main stimulus: directed rows under the reset timing, then the all-zero
    // and the all-one settings, then random settings with short timings.
    initial
    begin
        reg_vals_t vals;
        int base;
        int guard;
        cur_cfg = '{reset_low_ticks: 10'd480, presence_wait_ticks: 8'd60,
                    reset_tail_ticks: 9'd240, write_low_ticks: 6'd5,
                    write_hold_ticks: 8'd55, read_low_ticks: 6'd10,
                    read_sample_ticks: 6'd10, read_tail_ticks: 8'd50};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_rows[i].drain)
                drain_ticks();
            else
                send_item(dir_rows[i].fn, dir_rows[i].data, dir_rows[i].level,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // Zero in every register, with junk above the live bits where there is room.
        vals = '{10'h000, 10'h300, 10'h200, 10'h3C0, 10'h300, 10'h3C0, 10'h3C0, 10'h300};
        run_setting(vals, 4);
        vals = '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1};
        run_setting(vals, 3);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < NUM_REGS; i++)
                vals[i] = CFG_DATA_W'(($urandom << REG_W[i]) | $urandom_range(0, 4));
            run_setting(vals, $urandom_range(3, 6));
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        guard = 0;
        while (bus_res_due.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (bus_res_due.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d result transactions expected, none arrived", $time,
                     bus_res_due.size());
        end

        $display("Sent %0d input transactions under %0d timing settings; %0d results checked.",
                 items_sent, settings_run, results_seen);
        $display("Commands completed: %0d, commands turned away while busy: %0d.",
                 dones_seen, rejects_seen);
        if (mismatches == 0)
            $display("one_wire_bus_master: match");
        else
            $display("one_wire_bus_master: mismatch");
        $finish;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #4_000_000;
        $display("one_wire_bus_master: mismatch");
        $finish;
    end

endmodule
